[hw/rtl/growable_ring_byte_buffer_core_defines.svh]
`ifndef GROWABLE_RING_BYTE_BUFFER_CORE_DEFINES_SVH
`define GROWABLE_RING_BYTE_BUFFER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define GRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GRB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define GRB_ASSERT(lbl, prop, msg)
`define GRB_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[hw/rtl/grb_pkg.sv]
package grb_pkg;

  localparam int unsigned MaxBytes  = 4096;
  localparam int unsigned AddrW     = $clog2(MaxBytes);
  localparam int unsigned SizeW     = AddrW + 1;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [2:0] OpBeginAdd = 3'd0;
  localparam logic [2:0] OpAddByte  = 3'd1;
  localparam logic [2:0] OpRemove   = 3'd2;
  localparam logic [2:0] OpNext     = 3'd3;
  localparam logic [2:0] OpPeek     = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgInitialSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxSize     = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_ROOM = 3'd1,
    ST_CLAMPED = 3'd2,
    ST_IGNORED = 3'd3,
    ST_BEYOND  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CMD_BEGIN,
    CMD_BYTE,
    CMD_REMOVE,
    CMD_PEEK,
    CMD_REPORT
  } cmd_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_GROW,
    BS_COPY,
    BS_PEEK,
    BS_REPORT
  } bst_e;

  typedef struct packed {
    logic [2:0]       operation;
    logic [7:0]       data_byte;
    logic [SizeW-1:0] chunk_length;
    logic [SizeW-1:0] remove_count;
    logic [AddrW-1:0] peek_offset;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [AddrW-1:0] segment_start;
    logic [SizeW-1:0] segment_length;
    logic [7:0]       peek_byte;
    logic [SizeW-1:0] capacity;
    logic [AddrW-1:0] fill_level;
  } out_t;

  typedef struct packed {
    cmd_e             kind;
    logic [7:0]       data_byte;
    logic [SizeW-1:0] length;
    logic [AddrW-1:0] peek_offset;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_push_t;

  function automatic logic [SizeW-1:0] clamp_size(logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) begin
      r = SizeW'(1);
    end else if (v > SizeW'(MaxBytes)) begin
      r = SizeW'(MaxBytes);
    end
    return r;
  endfunction

endpackage

[hw/rtl/grb_in_if.sv]
interface grb_in_if;
  import grb_pkg::*;
  logic valid;
  logic ready;
  in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/grb_out_if.sv]
interface grb_out_if;
  import grb_pkg::*;
  logic valid;
  logic ready;
  out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/growable_ring_byte_buffer_core.sv]
// Growable ring byte buffer. Commands arrive on in_i, one beat per command:
// begin add, add data byte, remove, next segment and peek byte. Every command
// returns exactly one result beat on out_o with status, read segment, peeked
// byte, capacity and fill level. Both channels use valid/ready handshakes.
// A two-entry command queue sits between the decoder and the execution unit,
// and the result sits in an output register, so in_i keeps accepting beats
// while a result waits for out_o.ready.
// A command beat goes through the queue to the execution unit, which takes it
// in its idle state and writes its result from the report state into the result
// register; peek passes through the peek state and begin add through the grow
// state. The unit takes one command at a time while the queue accepts beats.
// A begin add doubles the capacity step by step; when the capacity grows the
// stored bytes are copied into the other byte bank at one byte per cycle.
// The user writes the initial capacity (index 0, which empties the buffer) or
// the capacity limit (index 1) on cfg only while idle; not enforced by the block.
// Reset empties the buffer, sets capacity to 256 and the capacity limit to 4096.
// When out_o stalls, the result register holds its beat, the execution unit
// holds one more finished command and two further commands fill the queue
// before in_i.ready drops.
module growable_ring_byte_buffer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  grb_in_if.sink                      in_i,
  grb_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [grb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [grb_pkg::SizeW-1:0]   cfg_data_i
);
  import grb_pkg::*;

  cmd_push_t push;
  logic      full;
  logic      pop;
  logic      empty;
  cmd_t      cmd;

  grb_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push)
  );

  grb_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (cmd),
    .empty_o (empty)
  );

  grb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .empty_i    (empty),
    .pop_o      (pop),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_o      (out_o)
  );

endmodule

[hw/rtl/grb_front.sv]
module grb_front (
  grb_in_if.sink             in_i,
  input  logic               full_i,
  output grb_pkg::cmd_push_t push_o
);
  import grb_pkg::*;

  cmd_t cmd;

  always_comb begin
    cmd             = '0;
    cmd.data_byte   = in_i.payload.data_byte;
    cmd.peek_offset = in_i.payload.peek_offset;
    cmd.length      = '0;
    unique case (in_i.payload.operation)
      OpBeginAdd: begin
        cmd.kind   = CMD_BEGIN;
        cmd.length = in_i.payload.chunk_length;
      end
      OpAddByte: begin
        cmd.kind = CMD_BYTE;
      end
      OpRemove: begin
        cmd.kind   = CMD_REMOVE;
        cmd.length = in_i.payload.remove_count;
      end
      OpPeek: begin
        cmd.kind = CMD_PEEK;
      end
      OpNext: begin
        cmd.kind = CMD_REPORT;
      end
      default: begin
        cmd.kind = CMD_REPORT;
      end
    endcase
  end

  assign in_i.ready   = ~full_i;
  assign push_o.valid = in_i.valid & ~full_i;
  assign push_o.cmd   = cmd;

endmodule

[hw/rtl/grb_cmd_fifo.sv]
module grb_cmd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  grb_pkg::cmd_push_t push_i,
  output logic               full_o,
  input  logic               pop_i,
  output grb_pkg::cmd_t      cmd_o,
  output logic               empty_o
);
  import grb_pkg::*;

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, wr_d;
  logic [FifoPtrW-1:0] rd_q, rd_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i.valid & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.cmd;
    end
  end

endmodule

[hw/rtl/grb_back.sv]
`include "growable_ring_byte_buffer_core_defines.svh"

module grb_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  grb_pkg::cmd_t                cmd_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  input  logic                         cfg_we_i,
  input  logic [grb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [grb_pkg::SizeW-1:0]    cfg_data_i,
  grb_out_if.source                    out_o
);
  import grb_pkg::*;

  logic [7:0]       mem0 [MaxBytes];
  logic [7:0]       mem1 [MaxBytes];
  logic [7:0]       rd0_q, rd1_q;
  logic [7:0]       rdata;
  logic [AddrW-1:0] rd_addr;
  logic             we;
  logic             wr_bank;
  logic [AddrW-1:0] wa;
  logic [7:0]       wd;

  bst_e             state_q, state_d;
  logic [AddrW-1:0] read_q, read_d;
  logic [AddrW-1:0] write_q, write_d;
  logic [AddrW-1:0] fill_q, fill_d;
  logic [SizeW-1:0] size_q, size_d;
  logic [SizeW-1:0] size_w_q, size_w_d;
  logic [SizeW-1:0] pending_q, pending_d;
  logic             acc_q, acc_d;
  logic [SizeW-1:0] max_q, max_d;
  logic             bank_q, bank_d;
  logic             grown_q, grown_d;
  logic             cpv_q, cpv_d;
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;

  cmd_t             cmd_q, cmd_d;
  logic [7:0]       pbyte_q, pbyte_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] src_q, src_d;
  logic [AddrW-1:0] cpa_q, cpa_d;
  out_t             out_q, out_d;

  logic [SizeW-1:0] limit;
  logic [SizeW-1:0] rcnt;
  logic [SizeW-1:0] rsum;
  logic [SizeW-1:0] psum;
  logic [SizeW:0]   need;
  logic [SizeW:0]   dbl;
  logic [SizeW-1:0] seg;

  assign rdata = bank_q ? rd1_q : rd0_q;
  assign limit = clamp_size(max_q);

  always_comb begin
    state_d     = state_q;
    read_d      = read_q;
    write_d     = write_q;
    fill_d      = fill_q;
    size_d      = size_q;
    size_w_d    = size_w_q;
    pending_d   = pending_q;
    acc_d       = acc_q;
    max_d       = max_q;
    bank_d      = bank_q;
    grown_d     = grown_q;
    cpv_d       = 1'b0;
    status_d    = status_q;
    cmd_d       = cmd_q;
    pbyte_d     = pbyte_q;
    cnt_d       = cnt_q;
    src_d       = src_q;
    cpa_d       = cpa_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    pop_o       = 1'b0;
    we          = 1'b0;
    wr_bank     = bank_q;
    wa          = write_q;
    wd          = cmd_q.data_byte;
    rd_addr     = src_q;
    rcnt        = '0;
    rsum        = '0;
    psum        = '0;
    need        = '0;
    dbl         = '0;
    seg         = '0;

    unique case (state_q)
      BS_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          cmd_d    = cmd_i;
          status_d = ST_OK;
          pbyte_d  = '0;
          state_d  = BS_REPORT;
          unique case (cmd_i.kind)
            CMD_BEGIN: begin
              size_w_d = size_q;
              grown_d  = 1'b0;
              state_d  = BS_GROW;
            end
            CMD_BYTE: begin
              if (acc_q && (pending_q != '0) && ({1'b0, fill_q} + 1'b1 < size_q)) begin
                we        = 1'b1;
                wr_bank   = bank_q;
                wa        = write_q;
                wd        = cmd_i.data_byte;
                write_d   = ({1'b0, write_q} + 1'b1 >= size_q) ? '0 : write_q + 1'b1;
                pending_d = pending_q - 1'b1;
                fill_d    = fill_q + 1'b1;
              end else begin
                status_d = ST_IGNORED;
              end
            end
            CMD_REMOVE: begin
              rcnt = cmd_i.length;
              if (cmd_i.length > {1'b0, fill_q}) begin
                rcnt     = {1'b0, fill_q};
                status_d = ST_CLAMPED;
              end
              rsum = {1'b0, read_q} + rcnt;
              if (rsum >= size_q) begin
                rsum = rsum - size_q;
              end
              read_d = rsum[AddrW-1:0];
              fill_d = fill_q - rcnt[AddrW-1:0];
            end
            CMD_PEEK: begin
              if (cmd_i.peek_offset < fill_q) begin
                psum = {1'b0, read_q} + {1'b0, cmd_i.peek_offset};
                if (psum >= size_q) begin
                  psum = psum - size_q;
                end
                rd_addr = psum[AddrW-1:0];
                state_d = BS_PEEK;
              end else begin
                status_d = ST_BEYOND;
              end
            end
            CMD_REPORT: begin
              state_d = BS_REPORT;
            end
          endcase
        end
      end
      BS_GROW: begin
        need = {1'b0, cmd_q.length} + {2'b0, fill_q};
        if (need >= {1'b0, size_w_q}) begin
          if (size_w_q >= limit) begin
            acc_d     = 1'b0;
            pending_d = '0;
            status_d  = ST_NO_ROOM;
            cnt_d     = '0;
            src_d     = read_q;
            state_d   = grown_q ? BS_COPY : BS_REPORT;
          end else begin
            dbl      = {size_w_q, 1'b0};
            size_w_d = (dbl > {1'b0, limit}) ? limit : dbl[SizeW-1:0];
            grown_d  = 1'b1;
          end
        end else begin
          acc_d     = 1'b1;
          pending_d = cmd_q.length;
          cnt_d     = '0;
          src_d     = read_q;
          state_d   = grown_q ? BS_COPY : BS_REPORT;
        end
      end
      BS_COPY: begin
        if (cpv_q) begin
          we      = 1'b1;
          wr_bank = ~bank_q;
          wa      = cpa_q;
          wd      = rdata;
        end
        if (cnt_q != fill_q) begin
          rd_addr = src_q;
          cpv_d   = 1'b1;
          cpa_d   = cnt_q;
          cnt_d   = cnt_q + 1'b1;
          src_d   = ({1'b0, src_q} + 1'b1 >= size_q) ? '0 : src_q + 1'b1;
        end else if (!cpv_q) begin
          bank_d  = ~bank_q;
          read_d  = '0;
          write_d = fill_q;
          size_d  = size_w_q;
          state_d = BS_REPORT;
        end
      end
      BS_PEEK: begin
        pbyte_d = rdata;
        state_d = BS_REPORT;
      end
      BS_REPORT: begin
        if (!out_valid_q || out_o.ready) begin
          seg = (read_q <= write_q) ? {1'b0, write_q - read_q} : size_q - {1'b0, read_q};
          out_d.status         = status_q;
          out_d.segment_start  = read_q;
          out_d.segment_length = seg;
          out_d.peek_byte      = pbyte_q;
          out_d.capacity       = size_q;
          out_d.fill_level     = fill_q;
          out_valid_d          = 1'b1;
          state_d              = BS_IDLE;
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      if (cfg_idx_i == CfgInitialSize) begin
        read_d    = '0;
        write_d   = '0;
        fill_d    = '0;
        pending_d = '0;
        acc_d     = 1'b0;
        size_d    = clamp_size(cfg_data_i);
      end else if (cfg_idx_i == CfgMaxSize) begin
        max_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      read_q      <= '0;
      write_q     <= '0;
      fill_q      <= '0;
      size_q      <= SizeW'(256);
      size_w_q    <= SizeW'(256);
      pending_q   <= '0;
      acc_q       <= 1'b0;
      max_q       <= SizeW'(MaxBytes);
      bank_q      <= 1'b0;
      grown_q     <= 1'b0;
      cpv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      read_q      <= read_d;
      write_q     <= write_d;
      fill_q      <= fill_d;
      size_q      <= size_d;
      size_w_q    <= size_w_d;
      pending_q   <= pending_d;
      acc_q       <= acc_d;
      max_q       <= max_d;
      bank_q      <= bank_d;
      grown_q     <= grown_d;
      cpv_q       <= cpv_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    pbyte_q <= pbyte_d;
    cnt_q   <= cnt_d;
    src_q   <= src_d;
    cpa_q   <= cpa_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we && !wr_bank) begin
      mem0[wa] <= wd;
    end
    rd0_q <= mem0[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (we && wr_bank) begin
      mem1[wa] <= wd;
    end
    rd1_q <= mem1[rd_addr];
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  `GRB_ASSERT(a_fill_below_size, ({1'b0, fill_q} < size_q), "fill level reached capacity")
  `GRB_ASSERT(a_read_below_size, ({1'b0, read_q} < size_q), "read index outside buffer")
  `GRB_ASSERT(a_copy_grows, (state_q == BS_COPY) |-> (size_w_q > size_q), "copy without growth")
  `GRB_ASSERT_NEVER(a_pending_needs_chunk, (pending_q != '0) && !acc_q, "pending bytes without chunk")

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import grb_pkg::*;

  localparam logic [2:0] OpSpareFirst = 3'd5;
  localparam logic [2:0] OpSpareLast  = 3'd7;

  localparam int unsigned FieldTop     = (1 << SizeW) - 1;
  localparam int unsigned ChunkBurst   = 40;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned StallLimit   = 60000;
  localparam int unsigned PrintLimit   = 100;
  localparam int unsigned NumPhases    = 8;

  localparam int unsigned PhaseInit  [NumPhases] = '{256, 4, 1, 64, 0, 8191, 16, 2};
  localparam int unsigned PhaseMax   [NumPhases] = '{4096, 64, 4096, 16, 0, 8191, 128, 3};
  localparam int unsigned PhaseItems [NumPhases] = '{180, 300, 220, 150, 60, 150, 300, 120};

  class ring_tracker;
    logic [7:0]  store [MaxBytes];
    logic [7:0]  spare [MaxBytes];
    int unsigned rd;
    int unsigned wr;
    int unsigned cap;
    int unsigned pending;
    int unsigned init_reg;
    int unsigned max_reg;
    bit          accepted;
    out_t        awaited [$];
    int unsigned results_seen;
    int unsigned mismatches;

    function new();
      foreach (store[i]) begin
        store[i] = '0;
      end
      init_reg = 256;
      max_reg = MaxBytes;
      results_seen = 0;
      mismatches = 0;
      restart();
    endfunction

    function int unsigned bounded(int unsigned v);
      if (v < 1) begin
        return 1;
      end
      if (v > MaxBytes) begin
        return MaxBytes;
      end
      return v;
    endfunction

    function int unsigned level();
      if (wr >= rd) begin
        return wr - rd;
      end
      return cap - rd + wr;
    endfunction

    function void restart();
      rd = 0;
      wr = 0;
      pending = 0;
      accepted = 1'b0;
      cap = bounded(init_reg);
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, int unsigned val);
      if (idx == CfgInitialSize) begin
        init_reg = val & FieldTop;
        restart();
      end else begin
        max_reg = val & FieldTop;
      end
    endfunction

    // Doubles the capacity up to the limit and packs the stored bytes down to index zero.
    function bit double_capacity();
      int unsigned limit;
      int unsigned fill;
      int unsigned src;
      int unsigned grown;
      int unsigned i;
      limit = bounded(max_reg);
      fill = level();
      if (cap >= limit) begin
        return 1'b0;
      end
      grown = cap * 2;
      if (grown > limit) begin
        grown = limit;
      end
      src = rd;
      for (i = 0; i < fill; i++) begin
        spare[i] = store[src];
        src++;
        if (src >= cap) begin
          src = 0;
        end
      end
      for (i = 0; i < fill; i++) begin
        store[i] = spare[i];
      end
      rd = 0;
      wr = fill;
      cap = grown;
      return 1'b1;
    endfunction

    function void apply_command(in_t c);
      out_t        r;
      status_e     st;
      int unsigned fill;
      int unsigned seg;
      int unsigned p;
      int unsigned count;
      bit          ok;
      r = '0;
      st = ST_OK;
      case (c.operation)
        OpBeginAdd: begin
          ok = 1'b1;
          while (c.chunk_length + level() >= cap) begin
            if (!double_capacity()) begin
              ok = 1'b0;
              break;
            end
          end
          if (ok) begin
            accepted = 1'b1;
            pending = c.chunk_length;
          end else begin
            accepted = 1'b0;
            pending = 0;
            st = ST_NO_ROOM;
          end
        end
        OpAddByte: begin
          if (accepted && pending > 0 && level() + 1 < cap) begin
            store[wr] = c.data_byte;
            wr++;
            if (wr >= cap) begin
              wr = 0;
            end
            pending--;
          end else begin
            st = ST_IGNORED;
          end
        end
        OpRemove: begin
          fill = level();
          count = c.remove_count;
          if (count > fill) begin
            count = fill;
            st = ST_CLAMPED;
          end
          rd += count;
          if (rd >= cap) begin
            rd -= cap;
          end
        end
        OpPeek: begin
          fill = level();
          if (c.peek_offset < fill) begin
            p = rd + c.peek_offset;
            if (p >= cap) begin
              p -= cap;
            end
            r.peek_byte = store[p];
          end else begin
            st = ST_BEYOND;
          end
        end
        default: begin
        end
      endcase
      seg = (rd <= wr) ? wr - rd : cap - rd;
      r.status = st;
      r.segment_start = AddrW'(rd);
      r.segment_length = SizeW'(seg);
      r.capacity = SizeW'(cap);
      r.fill_level = AddrW'(level());
      awaited.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < PrintLimit) begin
        $display("[%0t] result %0d: %s", $time, results_seen, msg);
      end
      mismatches++;
    endtask

    task check_result(out_t got);
      out_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        report_mismatch("result beat with no command outstanding");
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      end
      if (got.segment_start !== want.segment_start) begin
        report_mismatch($sformatf("segment_start %0d, expected %0d",
                                  got.segment_start, want.segment_start));
      end
      if (got.segment_length !== want.segment_length) begin
        report_mismatch($sformatf("segment_length %0d, expected %0d",
                                  got.segment_length, want.segment_length));
      end
      if (got.peek_byte !== want.peek_byte) begin
        report_mismatch($sformatf("peek_byte %0h, expected %0h",
                                  got.peek_byte, want.peek_byte));
      end
      if (got.capacity !== want.capacity) begin
        report_mismatch($sformatf("capacity %0d, expected %0d", got.capacity, want.capacity));
      end
      if (got.fill_level !== want.fill_level) begin
        report_mismatch($sformatf("fill_level %0d, expected %0d",
                                  got.fill_level, want.fill_level));
      end
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [SizeW-1:0]     cfg_data_i = '0;

  grb_in_if  cmd_if ();
  grb_out_if rsp_if ();

  ring_tracker ring = new();

  bit          calm = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned beats_sent = 0;
  int unsigned quiet_cycles = 0;

  growable_ring_byte_buffer_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (cmd_if),
    .out_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      ring.apply_command(cmd_if.payload);
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      ring.check_result(rsp_if.payload);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The result side stalls in short random bursts, and once for a long stretch
  // so that the command queue fills and the block stops taking beats.
  initial begin
    int unsigned stall;
    stall = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = LongHold;
      end else if (stall == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 14);
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic send(input logic [2:0] op, input int unsigned db, input int unsigned clen,
                      input int unsigned rcnt, input int unsigned poff, input bit counted);
    in_t         item;
    int unsigned gap;
    item.operation = op;
    item.data_byte = 8'(db);
    item.chunk_length = SizeW'(clen);
    item.remove_count = SizeW'(rcnt);
    item.peek_offset = AddrW'(poff);
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.payload <= item;
    @(posedge clk_i);
    while (!cmd_if.ready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    if (counted) begin
      beats_sent++;
    end
  endtask

  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (ring.awaited.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= SizeW'(val);
    ring.write_register(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic peek_stored();
    send(OpPeek, 0, 0, 0, ring.level() > 0 ? $urandom_range(0, ring.level() - 1) : 0, 1'b1);
  endtask

  task automatic run_directed();
    send(OpNext, 0, 0, 0, 0, 1'b1);
    send(OpPeek, 0, 0, 0, 0, 1'b1);
    send(OpRemove, 0, 0, MaxBytes, 0, 1'b1);
    send(OpAddByte, 8'h5a, 0, 0, 0, 1'b1);
    send(OpBeginAdd, 0, 0, 0, 0, 1'b1);
    send(OpAddByte, 8'ha5, 0, 0, 0, 1'b1);
    send(OpBeginAdd, 0, 4, 0, 0, 1'b1);
    send(OpAddByte, 8'h00, 0, 0, 0, 1'b1);
    send(OpAddByte, 8'hff, 0, 0, 0, 1'b1);
    send(OpAddByte, 8'h0f, 0, 0, 0, 1'b1);
    send(OpAddByte, 8'hf0, 0, 0, 0, 1'b1);
    // A new chunk announced before the old one is complete drops its tail.
    send(OpBeginAdd, 0, 5, 0, 0, 1'b1);
    send(OpAddByte, 8'h81, 0, 0, 0, 1'b1);
    send(OpBeginAdd, 0, 2, 0, 0, 1'b1);
    send(OpAddByte, 8'h7e, 0, 0, 0, 1'b1);
    send(OpAddByte, 8'h18, 0, 0, 0, 1'b1);
    send(OpAddByte, 8'h99, 0, 0, 0, 1'b1);
    send(OpPeek, 0, 0, 0, 0, 1'b1);
    send(OpPeek, 0, 0, 0, 6, 1'b1);
    send(OpPeek, 0, 0, 0, MaxBytes - 1, 1'b1);
    send(OpBeginAdd, 0, 300, 0, 0, 1'b1);
    send(OpRemove, 0, 0, 3, 0, 1'b1);
    send(OpBeginAdd, 0, FieldTop, 0, 0, 1'b1);
    send(OpAddByte, 8'h42, 0, 0, 0, 1'b1);
    send(OpSpareFirst, 8'hff, FieldTop, FieldTop, MaxBytes - 1, 1'b1);
    send(OpSpareLast, 0, 0, 0, 0, 1'b1);
  endtask

  // Mostly whole chunks with random content followed by reads and removes;
  // the rest is random noise over the full range of every field.
  task automatic run_random(input int unsigned budget);
    int unsigned target;
    int unsigned pick;
    int unsigned span;
    int unsigned nbytes;
    int unsigned steps;
    int unsigned i;
    logic [2:0]  op;
    target = beats_sent + budget;
    while (beats_sent < target) begin
      if ($urandom_range(0, 9) < 7) begin
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
          span = ring.cap - ring.level();
        end else if (pick == 1) begin
          span = ring.cap + $urandom_range(0, ring.cap);
          if (span > FieldTop) begin
            span = FieldTop;
          end
        end else begin
          span = $urandom_range(0, ring.cap < ChunkBurst ? ring.cap : ChunkBurst);
        end
        nbytes = (span > ChunkBurst) ? $urandom_range(0, ChunkBurst) : span;
        if ($urandom_range(0, 9) == 0) begin
          nbytes = $urandom_range(0, nbytes);
        end
        send(OpBeginAdd, 0, span, 0, 0, 1'b1);
        for (i = 0; i < nbytes; i++) begin
          send(OpAddByte, $urandom_range(0, 255), 0, 0, 0, 1'b1);
          if ($urandom_range(0, 11) == 0) begin
            peek_stored();
          end
        end
        steps = $urandom_range(0, 3);
        for (i = 0; i < steps; i++) begin
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            send(OpRemove, 0, 0, $urandom_range(0, ring.level()), 0, 1'b1);
          end else if (pick < 6) begin
            send(OpNext, 0, 0, 0, 0, 1'b1);
          end else begin
            peek_stored();
          end
        end
      end else begin
        op = 3'($urandom_range(0, OpSpareLast));
        send(op, $urandom_range(0, 255),
             $urandom_range(0, 7) == 0 ? $urandom_range(0, FieldTop) : $urandom_range(0, 16),
             $urandom_range(0, 1) == 0 ? $urandom_range(0, FieldTop) : $urandom_range(0, 16),
             $urandom_range(0, MaxBytes - 1),
             op inside {OpBeginAdd, OpRemove, OpNext, OpPeek});
      end
    end
  endtask

  initial begin
    int unsigned half;
    int unsigned p;
    cmd_if.valid = 1'b0;
    cmd_if.payload = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    for (p = 0; p < NumPhases; p++) begin
      settle();
      write_reg(CfgMaxSize, PhaseMax[p]);
      write_reg(CfgInitialSize, PhaseInit[p]);
      if (p == NumPhases - 1) begin
        calm = 1'b1;
      end
      half = PhaseItems[p] / 2;
      run_random(half);
      if (p == 1) begin
        hold_request = 1'b1;
      end
      if (p == 2) begin
        settle();
      end
      run_random(PhaseItems[p] - half);
    end
    settle();
    if (ring.mismatches == 0 && ring.awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
